// File: rtl/core/ukvt_pkg.sv
// Shared operation codes and result type for the key/value table.
`timescale 1ns / 1ps

package ukvt_pkg;

  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_DELETE = 2'd2;

  localparam int unsigned KEY_W = 16;
  localparam int unsigned VAL_W = 16;
  localparam int unsigned OUT_CNT_W = 5;

  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
    logic                    insert_rejected;
    logic [OUT_CNT_W-1:0]    entry_count;
    logic                    is_full;
    logic                    is_empty;
  } res_t;

endpackage

// File: rtl/core/unordered_key_value_table.sv
// Top level of the unordered key/value table with a sequential linear search.
//
// Usage: each request on the in_ channel carries an operation (lookup, insert,
// delete), a key and a value. The table keeps up to CAPACITY pairs packed in a
// single memory and answers every request with exactly one result on the out_
// channel. A request is taken when in_valid is high and in_stall is low.
// The block takes one request at a time. One memory read port is reused for
// the key search, one entry per cycle. The search is followed by a read of the
// last entry on a delete (S_RDLAST), a write-back on a table change (S_WB)
// and a done state (S_DONE) that hands the result to the output register.
// The result sits in an output register; a new request is taken while it
// waits, but the block holds a finished result until the receiver releases
// out_stall. Reset (rst_n low, synchronous) empties the table and sets the
// not-found value to -1. cfg_we writes the not-found value and is meant to be
// used only while no request is in flight.
`timescale 1ns / 1ps

module unordered_key_value_table
  import ukvt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic signed [VAL_W-1:0] cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_func,
  input  logic [KEY_W-1:0]        in_key,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_found,
  output logic signed [VAL_W-1:0] out_read_value,
  output logic                    out_insert_rejected,
  output logic [OUT_CNT_W-1:0]    out_entry_count,
  output logic                    out_is_full,
  output logic                    out_is_empty
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_RDLAST = 5'b00100,
    S_WB     = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic signed [VAL_W-1:0] nf_r;
  logic [1:0]              func_r;
  logic [KEY_W-1:0]        key_r;
  logic signed [VAL_W-1:0] val_in_r;
  logic                    hit_r, hit_nxt;
  logic [IDX_W-1:0]        slot_r, slot_nxt;
  logic signed [VAL_W-1:0] hval_r, hval_nxt;
  logic                    rej_r, rej_nxt;
  logic [CNT_W-1:0]        issue_r, issue_nxt;
  logic                    chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]        chk_idx_r, chk_idx_nxt;

  logic [KEY_W+VAL_W-1:0]  kv_mem [CAPACITY];
  logic [KEY_W+VAL_W-1:0]  rd_q;
  logic                    rd_en;
  logic [IDX_W-1:0]        rd_addr;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic [KEY_W+VAL_W-1:0]  wr_data;

  logic [KEY_W-1:0]        rd_key;
  logic signed [VAL_W-1:0] rd_val;
  logic [CNT_W-1:0]        last_cnt;
  logic                    tbl_full;
  logic                    match;
  logic                    scan_end;
  logic                    hit_now;
  logic                    in_acc;
  logic                    orq_busy;
  logic                    res_load;
  logic [CNT_W+OUT_CNT_W-1:0] cnt_ext;
  res_t                    res;

  assign rd_key   = rd_q[KEY_W+VAL_W-1:VAL_W];
  assign rd_val   = rd_q[VAL_W-1:0];
  assign last_cnt = count_r - ONE_CNT;
  assign tbl_full = (count_r == CAP_CNT);
  assign match    = chk_vld_r && (rd_key == key_r);
  assign scan_end = !chk_vld_r && (issue_r == count_r);
  assign hit_now  = match;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign res_load = (state_r == S_DONE) && !orq_busy;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    hit_nxt     = hit_r;
    slot_nxt    = slot_r;
    hval_nxt    = hval_r;
    rej_nxt     = rej_r;
    issue_nxt   = issue_r;
    chk_vld_nxt = chk_vld_r;
    chk_idx_nxt = chk_idx_r;
    rd_en       = 1'b0;
    rd_addr     = issue_r[IDX_W-1:0];
    wr_en       = 1'b0;
    wr_addr     = count_r[IDX_W-1:0];
    wr_data     = {key_r, val_in_r};
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          issue_nxt   = '0;
          chk_vld_nxt = 1'b0;
          hit_nxt     = 1'b0;
          rej_nxt     = 1'b0;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (match || scan_end) begin
          hit_nxt     = hit_now;
          slot_nxt    = chk_idx_r;
          hval_nxt    = rd_val;
          chk_vld_nxt = 1'b0;
          if (func_r == FUNC_INSERT && !hit_now) begin
            if (tbl_full) begin
              rej_nxt   = 1'b1;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_WB;
            end
          end else if (func_r == FUNC_DELETE && hit_now) begin
            state_nxt = S_RDLAST;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (issue_r != count_r) begin
          rd_en       = 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = issue_r[IDX_W-1:0];
          issue_nxt   = issue_r + ONE_CNT;
        end else begin
          chk_vld_nxt = 1'b0;
        end
      end
      S_RDLAST: begin
        rd_en     = 1'b1;
        rd_addr   = last_cnt[IDX_W-1:0];
        state_nxt = S_WB;
      end
      S_WB: begin
        wr_en = 1'b1;
        if (func_r == FUNC_DELETE) begin
          wr_addr   = slot_r;
          wr_data   = rd_q;
          count_nxt = last_cnt;
        end else begin
          count_nxt = count_r + ONE_CNT;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!orq_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      nf_r      <= '1;
      chk_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      chk_vld_r <= chk_vld_nxt;
      if (cfg_we) begin
        nf_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r   <= in_func;
      key_r    <= in_key;
      val_in_r <= in_value;
    end
    hit_r     <= hit_nxt;
    slot_r    <= slot_nxt;
    hval_r    <= hval_nxt;
    rej_r     <= rej_nxt;
    issue_r   <= issue_nxt;
    chk_idx_r <= chk_idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      kv_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= kv_mem[rd_addr];
    end
  end

  assign cnt_ext = {{OUT_CNT_W{1'b0}}, count_r};

  always_comb begin
    res.found           = hit_r;
    res.read_value      = (func_r == FUNC_LOOKUP && hit_r) ? hval_r : nf_r;
    res.insert_rejected = rej_r;
    res.entry_count     = cnt_ext[OUT_CNT_W-1:0];
    res.is_full         = tbl_full;
    res.is_empty        = (count_r == '0);
  end

  ukvt_out_reg u_out_reg (
    .clk                 (clk),
    .rst_n               (rst_n),
    .load                (res_load),
    .res                 (res),
    .busy                (orq_busy),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_found           (out_found),
    .out_read_value      (out_read_value),
    .out_insert_rejected (out_insert_rejected),
    .out_entry_count     (out_entry_count),
    .out_is_full         (out_is_full),
    .out_is_empty        (out_is_empty)
  );

`ifndef SYNTH
  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("Entry count exceeds the table capacity.");

  a_wb_changes_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WB |=> count_r != $past(count_r))
    else $error("A write-back did not change the entry count.");

  a_reject_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_load && rej_r |-> tbl_full && func_r == FUNC_INSERT && !hit_r)
    else $error("An insert was rejected while the table had room.");

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_read_value) && $stable(out_entry_count))
    else $error("A held result was overwritten.");
`endif

endmodule

// File: rtl/core/ukvt_out_reg.sv
// Output register stage that holds one finished result until it is taken.
`timescale 1ns / 1ps

module ukvt_out_reg
  import ukvt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  res_t                    res,
  output logic                    busy,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_found,
  output logic signed [VAL_W-1:0] out_read_value,
  output logic                    out_insert_rejected,
  output logic [OUT_CNT_W-1:0]    out_entry_count,
  output logic                    out_is_full,
  output logic                    out_is_empty
);

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  assign busy = valid_r && out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid           = valid_r;
  assign out_found           = res_r.found;
  assign out_read_value      = res_r.read_value;
  assign out_insert_rejected = res_r.insert_rejected;
  assign out_entry_count     = res_r.entry_count;
  assign out_is_full         = res_r.is_full;
  assign out_is_empty        = res_r.is_empty;

endmodule

// File: sim/ukvt_checker.sv
// Checker for the key/value table: predicts each request's result and compares it.
`timescale 1ns / 1ps

module ukvt_checker
  import ukvt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic signed [VAL_W-1:0] cfg_wdata,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [1:0]              in_func,
  input  logic [KEY_W-1:0]        in_key,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic                    out_found,
  input  logic signed [VAL_W-1:0] out_read_value,
  input  logic                    out_insert_rejected,
  input  logic [OUT_CNT_W-1:0]    out_entry_count,
  input  logic                    out_is_full,
  input  logic                    out_is_empty,
  output int                      mismatches,
  output int                      pending,
  output int                      results_seen,
  output int                      hits_seen,
  output int                      rejects_seen,
  output int                      full_seen,
  output int                      empty_seen
);

  logic [KEY_W-1:0]        table_keys [CAPACITY];
  logic signed [VAL_W-1:0] table_vals [CAPACITY];
  int                      table_used;
  logic signed [VAL_W-1:0] miss_value;
  res_t                    expected_results [$];
  int                      err_cnt;
  int                      n_results;
  int                      n_hits;
  int                      n_rejects;
  int                      n_full;
  int                      n_empty;

  function automatic res_t apply_request(input logic [1:0] func,
                                         input logic [KEY_W-1:0] key,
                                         input logic signed [VAL_W-1:0] value);
    res_t r;
    int   slot;
    int   i;
    slot = -1;
    for (i = 0; i < table_used; i++) begin
      if (slot < 0 && table_keys[i] == key) slot = i;
    end
    r.found = (slot >= 0);
    r.read_value = miss_value;
    r.insert_rejected = 1'b0;
    case (func)
      FUNC_LOOKUP: begin
        if (slot >= 0) r.read_value = table_vals[slot];
      end
      FUNC_INSERT: begin
        if (slot < 0) begin
          if (table_used < CAPACITY) begin
            table_keys[table_used] = key;
            table_vals[table_used] = value;
            table_used++;
          end else begin
            r.insert_rejected = 1'b1;
          end
        end
      end
      FUNC_DELETE: begin
        if (slot >= 0) begin
          table_keys[slot] = table_keys[table_used-1];
          table_vals[slot] = table_vals[table_used-1];
          table_used--;
        end
      end
      default: begin
      end
    endcase
    r.entry_count = OUT_CNT_W'(table_used);
    r.is_full = (table_used == CAPACITY);
    r.is_empty = (table_used == 0);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      table_used = 0;
      miss_value = -16'sd1;
      expected_results.delete();
      err_cnt = 0;
      n_results = 0;
      n_hits = 0;
      n_rejects = 0;
      n_full = 0;
      n_empty = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result arrived with no request waiting for it");
          err_cnt++;
        end else begin
          want = expected_results.pop_front();
          check_field("found", want.found, out_found);
          check_field("read_value", $signed(want.read_value), $signed(out_read_value));
          check_field("insert_rejected", want.insert_rejected, out_insert_rejected);
          check_field("entry_count", want.entry_count, out_entry_count);
          check_field("is_full", want.is_full, out_is_full);
          check_field("is_empty", want.is_empty, out_is_empty);
          n_results++;
          if (want.found) n_hits++;
          if (want.insert_rejected) n_rejects++;
          if (want.is_full) n_full++;
          if (want.is_empty) n_empty++;
        end
      end
      if (cfg_we) miss_value = cfg_wdata;
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_request(in_func, in_key, in_value));
      end
    end
    mismatches <= err_cnt;
    pending <= expected_results.size();
    results_seen <= n_results;
    hits_seen <= n_hits;
    rejects_seen <= n_rejects;
    full_seen <= n_full;
    empty_seen <= n_empty;
  end

endmodule

// File: sim/tb_unordered_key_value_table.sv
// Testbench top for the key/value table: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_unordered_key_value_table;
  import ukvt_pkg::*;

  localparam int unsigned CAPACITY = 16;
  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int POOL = 20;
  localparam int PHASES = 6;
  localparam int PHASE_REQS = 115;
  localparam int HOLD_LEN = 80;
  localparam int DRAIN_CYCLES = 4;
  localparam int TAIL_CYCLES = 30;
  localparam int QUIET_LIMIT = 3000;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic signed [VAL_W-1:0] cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              in_func = FUNC_LOOKUP;
  logic [KEY_W-1:0]        in_key = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_found;
  logic signed [VAL_W-1:0] out_read_value;
  logic                    out_insert_rejected;
  logic [OUT_CNT_W-1:0]    out_entry_count;
  logic                    out_is_full;
  logic                    out_is_empty;

  int mismatches;
  int pending;
  int results_seen;
  int hits_seen;
  int rejects_seen;
  int full_seen;
  int empty_seen;

  logic             calm = 1'b0;
  int               hold_reqs = 0;
  int               hold_taken = 0;
  int               hold_left = 0;
  int               quiet = 0;
  int               sent = 0;
  int               cfg_writes = 0;
  logic [KEY_W-1:0] key_pool [POOL];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  unordered_key_value_table #(.CAPACITY(CAPACITY)) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_key              (in_key),
    .in_value            (in_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_found           (out_found),
    .out_read_value      (out_read_value),
    .out_insert_rejected (out_insert_rejected),
    .out_entry_count     (out_entry_count),
    .out_is_full         (out_is_full),
    .out_is_empty        (out_is_empty)
  );

  ukvt_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_key              (in_key),
    .in_value            (in_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_found           (out_found),
    .out_read_value      (out_read_value),
    .out_insert_rejected (out_insert_rejected),
    .out_entry_count     (out_entry_count),
    .out_is_full         (out_is_full),
    .out_is_empty        (out_is_empty),
    .mismatches          (mismatches),
    .pending             (pending),
    .results_seen        (results_seen),
    .hits_seen           (hits_seen),
    .rejects_seen        (rejects_seen),
    .full_seen           (full_seen),
    .empty_seen          (empty_seen)
  );

  // A hold-off request from the stimulus keeps the result channel stalled until the hold counter runs out.
  always @(posedge clk) begin
    if (hold_reqs != hold_taken) begin
      hold_taken <= hold_reqs;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 23);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_req(input logic [1:0] func, input logic [KEY_W-1:0] key,
                          input logic signed [VAL_W-1:0] value);
    int gap;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(99) < 23) gap++;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_key <= key;
    in_value <= value;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic random_req(input int insert_pct, input int delete_pct);
    int               pick;
    logic [1:0]       func;
    logic [KEY_W-1:0] key;
    pick = $urandom_range(99);
    if (pick < 2) func = FUNC_NONE;
    else if (pick < 2 + insert_pct) func = FUNC_INSERT;
    else if (pick < 2 + insert_pct + delete_pct) func = FUNC_DELETE;
    else func = FUNC_LOOKUP;
    if ($urandom_range(99) < 8) key = KEY_W'($urandom);
    else key = key_pool[$urandom_range(POOL - 1)];
    send_req(func, key, VAL_W'($urandom));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_miss_value(input logic signed [VAL_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    int                      ph;
    int                      n;
    int                      i;
    logic signed [VAL_W-1:0] miss;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests run with the reset not-found value.
    send_req(FUNC_LOOKUP, 16'h0000, 16'sh0000);
    send_req(FUNC_DELETE, 16'h0000, 16'sh0000);
    send_req(FUNC_INSERT, 16'h0000, 16'sh8000);
    send_req(FUNC_INSERT, 16'hFFFF, 16'sh7FFF);
    send_req(FUNC_INSERT, 16'h0000, 16'sh1234);
    send_req(FUNC_LOOKUP, 16'hFFFF, 16'sh0000);
    send_req(FUNC_NONE, 16'hFFFF, 16'sh5555);
    send_req(FUNC_DELETE, 16'h0000, 16'sh0000);
    send_req(FUNC_LOOKUP, 16'hFFFF, 16'sh0000);
    send_req(FUNC_DELETE, 16'h1234, 16'sh0000);
    for (i = 0; i < CAPACITY - 1; i++) begin
      send_req(FUNC_INSERT, KEY_W'(16'h0100 + i), VAL_W'($urandom));
    end
    send_req(FUNC_INSERT, 16'hA5A5, 16'sh2222);
    send_req(FUNC_INSERT, 16'hFFFF, 16'sh3333);

    for (ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: miss = 16'sh8000;
        1: miss = 16'sh7FFF;
        2: miss = 16'sh0000;
        4: miss = -16'sd1;
        default: miss = VAL_W'($urandom);
      endcase
      write_miss_value(miss);
      if (ph % 2 == 0) begin
        for (i = 0; i < POOL; i++) key_pool[i] = KEY_W'($urandom);
      end
      calm <= (ph == 2);
      for (n = 0; n < PHASE_REQS; n++) begin
        if ((ph == 1 || ph == 4) && n == 20) hold_reqs <= hold_reqs + 1;
        if (ph % 2 == 0) random_req(55, 15);
        else random_req(15, 55);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d requests under %0d not-found settings; %0d results checked.",
             sent, cfg_writes + 1, results_seen);
    $display("Keys found %0d times, %0d inserts rejected, %0d full and %0d empty results.",
             hits_seen, rejects_seen, full_seen, empty_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/ukvt_pkg.sv
rtl/core/ukvt_out_reg.sv
rtl/core/unordered_key_value_table.sv
sim/ukvt_checker.sv
sim/tb_unordered_key_value_table.sv
